/* rtl/hidkb_pkg.sv */
// ----------------------------------------------------------------------------
// hidkb_pkg
// shared types, constants and the ascii lookup table of the keyboard report
// builder
// ----------------------------------------------------------------------------
package hidkb_pkg;

   localparam int KEY_SLOTS = 6;  // key slots kept in the report, 1 to 14
   localparam int OUT_SLOTS = 6;  // key slots carried on the result channel

   localparam logic [7:0] HID_OVF    = 8'h01;
   localparam logic [7:0] USAGE_NONE = 8'h00;

   typedef enum logic [1:0] {
      MODE_PRESS   = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_RESET   = 2'd2,
      MODE_ASCII   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] usage;
      logic [7:0] modifier_bits;
      logic [7:0] ascii_char;
   } req_item_type;

   typedef struct packed {
      logic [7:0]                    modifiers;
      logic [OUT_SLOTS-1:0][7:0]     slots;
      logic                          last;
   } report_type;

   // modifier in the high byte, usage in the low byte (us layout)
   localparam logic [15:0] CHAR_MAP [128] = '{
      16'h011F, 16'h0104, 16'h0105, 16'h0106, 16'h0107, 16'h0108, 16'h0109, 16'h010A,
      16'h002A, 16'h002B, 16'h0028, 16'h010E, 16'h010F, 16'h0110, 16'h0111, 16'h0112,
      16'h0113, 16'h0114, 16'h0115, 16'h0116, 16'h0117, 16'h0118, 16'h0119, 16'h011A,
      16'h011B, 16'h011C, 16'h011D, 16'h0029, 16'h0131, 16'h0130, 16'h0123, 16'h012D,
      16'h002C, 16'h021E, 16'h0234, 16'h0220, 16'h0221, 16'h0222, 16'h0224, 16'h0034,
      16'h0226, 16'h0227, 16'h0225, 16'h022E, 16'h0036, 16'h002D, 16'h0037, 16'h0038,
      16'h0027, 16'h001E, 16'h001F, 16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024,
      16'h0025, 16'h0026, 16'h0233, 16'h0033, 16'h0236, 16'h002E, 16'h0237, 16'h0238,
      16'h021F, 16'h0204, 16'h0205, 16'h0206, 16'h0207, 16'h0208, 16'h0209, 16'h020A,
      16'h020B, 16'h020C, 16'h020D, 16'h020E, 16'h020F, 16'h0210, 16'h0211, 16'h0212,
      16'h0213, 16'h0214, 16'h0215, 16'h0216, 16'h0217, 16'h0218, 16'h0219, 16'h021A,
      16'h021B, 16'h021C, 16'h021D, 16'h002F, 16'h0031, 16'h0030, 16'h0223, 16'h022D,
      16'h0035, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000A,
      16'h000B, 16'h000C, 16'h000D, 16'h000E, 16'h000F, 16'h0010, 16'h0011, 16'h0012,
      16'h0013, 16'h0014, 16'h0015, 16'h0016, 16'h0017, 16'h0018, 16'h0019, 16'h001A,
      16'h001B, 16'h001C, 16'h001D, 16'h022F, 16'h0231, 16'h0230, 16'h0235, 16'h002A
   };

   // characters above 127 map to no modifier and no key
   function automatic logic [15:0] ascii_code(input logic [7:0] ch);
      logic [15:0] code;
      if (ch[7]) begin
         code = 16'h0000;
      end else begin
         code = CHAR_MAP[ch[6:0]];
      end
      return code;
   endfunction

endpackage

/* rtl/hid_keyboard_report_builder.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder
// usb boot keyboard report builder with six-key rollover and ascii typing
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  req_    | in        | req_valid/stall    | mode, usage, modifier_bits, char
//  rsp_    | out       | rsp_valid/stall    | modifiers, six key slots, last
//
//  an item is held in the input register, then its report is built in
//  one pass from the held report and written to the result register
//  key items give one transfer per item, so one item a cycle when rsp_stall is
//  low; an ascii item gives two transfers and holds the result register until
//  its release report is taken, so the next item waits in the input register
//  reset is synchronous and clears the held report and both valid flags
//  rsp_stall backs up into req_stall through the input register in the same
//  cycle
//
module hid_keyboard_report_builder
   import hidkb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_usage,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_ascii_char,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_modifiers,
   output logic [7:0] rsp_key_slot_one,
   output logic [7:0] rsp_key_slot_two,
   output logic [7:0] rsp_key_slot_three,
   output logic [7:0] rsp_key_slot_four,
   output logic [7:0] rsp_key_slot_five,
   output logic [7:0] rsp_key_slot_six,
   output logic       rsp_last_of_run
);

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_ff;
   req_item_type in_in;

   logic         accept;      // input transfer
   logic         advance;     // item moves into the result register
   logic         free;        // result register can take a new report
   report_type   rep;
   report_type   rsp_rep;

   // the input register moves on whenever the result side has room
   assign advance   = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_in.mode          = mode_type'(req_mode);
         in_in.usage         = req_usage;
         in_in.modifier_bits = req_modifier_bits;
         in_in.ascii_char    = req_ascii_char;
         in_valid_in         = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // held report, state update and report build
   hidkb_key_table u_key_table (
      .clock (clock),
      .reset (reset),
      .load  (advance),
      .item  (in_ff),
      .rep   (rep)
   );

   // result register, also plays out the ascii release report
   hidkb_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rep       (rep),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_rep   (rsp_rep),
      .free      (free)
   );

   assign rsp_modifiers      = rsp_rep.modifiers;
   assign rsp_key_slot_one   = rsp_rep.slots[0];
   assign rsp_key_slot_two   = rsp_rep.slots[1];
   assign rsp_key_slot_three = rsp_rep.slots[2];
   assign rsp_key_slot_four  = rsp_rep.slots[3];
   assign rsp_key_slot_five  = rsp_rep.slots[4];
   assign rsp_key_slot_six   = rsp_rep.slots[5];
   assign rsp_last_of_run    = rsp_rep.last;

   // a taken press report of an ascii item is followed by the zero release
   a_release_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=>
         rsp_valid && rsp_last_of_run && rsp_modifiers == 8'h00 &&
         rsp_key_slot_one == USAGE_NONE)
      else $error("ascii release report missing after press report");

   // an item that moves on shows up as a result in the next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result register empty after an item moved in");

   // an item held in the input register is not dropped
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost or changed a waiting item");

endmodule

/* rtl/hidkb_key_table.sv */
// ----------------------------------------------------------------------------
// hidkb_key_table
// held modifier byte and packed key slots, with the update and report logic
// for one item
// ----------------------------------------------------------------------------
module hidkb_key_table
   import hidkb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  req_item_type item,
   output report_type   rep
);

   logic [7:0]                   held_mods_ff;
   logic [7:0]                   held_mods_in;
   logic [KEY_SLOTS-1:0][7:0]    held_keys_ff;
   logic [KEY_SLOTS-1:0][7:0]    held_keys_in;

   logic [KEY_SLOTS:0][7:0]      keys_ext;
   logic [KEY_SLOTS-1:0][7:0]    press_keys;
   logic [KEY_SLOTS-1:0][7:0]    rel_keys;
   logic [KEY_SLOTS-1:0][7:0]    keys_nx;
   logic [7:0]                   mods_nx;
   logic                         has_usage;
   logic                         taken;
   logic                         seen;
   logic                         overflow;
   logic [15:0]                  code;

   assign keys_ext  = {USAGE_NONE, held_keys_ff};
   assign has_usage = (item.usage != USAGE_NONE);
   assign code      = ascii_code(item.ascii_char);

   // press: first slot that is empty or already holds the usage
   always_comb begin
      taken = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         press_keys[i] = held_keys_ff[i];
         if (!taken && (held_keys_ff[i] == USAGE_NONE || held_keys_ff[i] == item.usage)) begin
            press_keys[i] = item.usage;
            taken         = 1'b1;
         end
      end
   end

   // release: from the matching slot on, pull the later slots down
   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         seen        = seen | (held_keys_ff[i] == item.usage);
         rel_keys[i] = seen ? keys_ext[i+1] : keys_ext[i];
      end
   end

   always_comb begin
      mods_nx  = held_mods_ff;
      keys_nx  = held_keys_ff;
      overflow = 1'b0;
      case (item.mode)
         MODE_PRESS: begin
            mods_nx = held_mods_ff | item.modifier_bits;
            if (has_usage) begin
               if (taken) begin
                  keys_nx = press_keys;
               end else begin
                  overflow = 1'b1;
               end
            end
         end
         MODE_RELEASE: begin
            mods_nx = held_mods_ff & ~item.modifier_bits;
            if (has_usage) begin
               keys_nx = rel_keys;
            end
         end
         MODE_RESET: begin
            mods_nx = '0;
            keys_nx = '0;
         end
         default: begin
         end
      endcase
   end

   assign held_mods_in = load ? mods_nx : held_mods_ff;
   assign held_keys_in = load ? keys_nx : held_keys_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mods_ff <= '0;
         held_keys_ff <= '0;
      end else begin
         held_mods_ff <= held_mods_in;
         held_keys_ff <= held_keys_in;
      end
   end

   // report for the item; an ascii item gives its press report here
   genvar j;
   generate
      for (j = 0; j < OUT_SLOTS; j++) begin : g_slot
         logic [7:0] held_slot;
         logic [7:0] ascii_slot;
         if (j < KEY_SLOTS) begin : g_kept
            assign held_slot = keys_nx[j];
         end else begin : g_absent
            assign held_slot = USAGE_NONE;
         end
         assign ascii_slot   = (j == 0) ? code[7:0] : USAGE_NONE;
         assign rep.slots[j] = (item.mode == MODE_ASCII) ? ascii_slot :
                               overflow                  ? HID_OVF    : held_slot;
      end
   endgenerate

   assign rep.modifiers = (item.mode == MODE_ASCII) ? code[15:8] : mods_nx;
   assign rep.last      = (item.mode != MODE_ASCII);

endmodule

/* rtl/hidkb_rsp_stage.sv */
// ----------------------------------------------------------------------------
// hidkb_rsp_stage
// result register; after a press report that is not last it turns into the
// all-zero release report
// ----------------------------------------------------------------------------
module hidkb_rsp_stage
   import hidkb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  report_type rep,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output report_type rsp_rep,
   output logic       free
);

   logic       out_valid_ff;
   logic       out_valid_in;
   report_type out_ff;
   report_type out_in;
   logic       take;

   assign take = out_valid_ff && !rsp_stall;
   assign free = !out_valid_ff || (take && out_ff.last);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_in       = rep;
      end else if (take) begin
         if (out_ff.last) begin
            out_valid_in = 1'b0;
         end else begin
            out_in      = '0;
            out_in.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rep   = out_ff;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench of the keyboard report builder: directed keystrokes, long random
// typing runs and a long receiver hold-off, every report checked against a
// behavioral copy of the held report
// ----------------------------------------------------------------------------
module tb_top
   import hidkb_pkg::*;
();

   localparam int RANDOM_ITEMS    = 1650;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_ITEMS  = 40;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_TIME   = 4_000_000;
   localparam int POOL_SIZE       = 12;

   // us layout: modifier in the high byte, usage in the low byte
   localparam logic [15:0] US_KEYMAP [128] = '{
      16'h011F, 16'h0104, 16'h0105, 16'h0106, 16'h0107, 16'h0108, 16'h0109, 16'h010A,
      16'h002A, 16'h002B, 16'h0028, 16'h010E, 16'h010F, 16'h0110, 16'h0111, 16'h0112,
      16'h0113, 16'h0114, 16'h0115, 16'h0116, 16'h0117, 16'h0118, 16'h0119, 16'h011A,
      16'h011B, 16'h011C, 16'h011D, 16'h0029, 16'h0131, 16'h0130, 16'h0123, 16'h012D,
      16'h002C, 16'h021E, 16'h0234, 16'h0220, 16'h0221, 16'h0222, 16'h0224, 16'h0034,
      16'h0226, 16'h0227, 16'h0225, 16'h022E, 16'h0036, 16'h002D, 16'h0037, 16'h0038,
      16'h0027, 16'h001E, 16'h001F, 16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024,
      16'h0025, 16'h0026, 16'h0233, 16'h0033, 16'h0236, 16'h002E, 16'h0237, 16'h0238,
      16'h021F, 16'h0204, 16'h0205, 16'h0206, 16'h0207, 16'h0208, 16'h0209, 16'h020A,
      16'h020B, 16'h020C, 16'h020D, 16'h020E, 16'h020F, 16'h0210, 16'h0211, 16'h0212,
      16'h0213, 16'h0214, 16'h0215, 16'h0216, 16'h0217, 16'h0218, 16'h0219, 16'h021A,
      16'h021B, 16'h021C, 16'h021D, 16'h002F, 16'h0031, 16'h0030, 16'h0223, 16'h022D,
      16'h0035, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000A,
      16'h000B, 16'h000C, 16'h000D, 16'h000E, 16'h000F, 16'h0010, 16'h0011, 16'h0012,
      16'h0013, 16'h0014, 16'h0015, 16'h0016, 16'h0017, 16'h0018, 16'h0019, 16'h001A,
      16'h001B, 16'h001C, 16'h001D, 16'h022F, 16'h0231, 16'h0230, 16'h0235, 16'h002A
   };

   // clock, reset and block ports; the ones the bench drives are known from time zero
   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode           = MODE_PRESS;
   logic [7:0] req_usage          = 8'h00;
   logic [7:0] req_modifier_bits  = 8'h00;
   logic [7:0] req_ascii_char     = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall          = 1'b0;
   logic [7:0] rsp_modifiers;
   logic [7:0] rsp_key_slot_one;
   logic [7:0] rsp_key_slot_two;
   logic [7:0] rsp_key_slot_three;
   logic [7:0] rsp_key_slot_four;
   logic [7:0] rsp_key_slot_five;
   logic [7:0] rsp_key_slot_six;
   logic       rsp_last_of_run;

   // predicted keyboard state and the reports still owed by the block
   logic [7:0] held_mods;
   logic [7:0] held_usages [KEY_SLOTS];
   report_type pending_reports [$];

   // traffic shaping knobs, changed by the tests
   bit  sender_gaps   = 1'b0;   // sender works in bursts with gaps
   bit  receiver_gaps = 1'b0;   // receiver stalls in runs
   int  burst_left    = 0;
   int  hold_request  = 0;      // long hold-off asked by a test
   int  hold_left     = 0;
   int  stall_run     = 0;
   bit  stall_phase   = 1'b0;

   int  mismatch_count = 0;
   int  rsp_count      = 0;

   logic [7:0] key_pool [POOL_SIZE];

   hid_keyboard_report_builder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_usage          (req_usage),
      .req_modifier_bits  (req_modifier_bits),
      .req_ascii_char     (req_ascii_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_modifiers      (rsp_modifiers),
      .rsp_key_slot_one   (rsp_key_slot_one),
      .rsp_key_slot_two   (rsp_key_slot_two),
      .rsp_key_slot_three (rsp_key_slot_three),
      .rsp_key_slot_four  (rsp_key_slot_four),
      .rsp_key_slot_five  (rsp_key_slot_five),
      .rsp_key_slot_six   (rsp_key_slot_six),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // 8 unit period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit, far above the slowest correct run
   initial begin
      #(WATCHDOG_TIME);
      $display("tb_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // report of the held state; an overflow report fills every slot with the
   // overflow code and keeps the modifiers
   function automatic report_type held_report(input bit overflow);
      report_type rpt;
      rpt.modifiers = held_mods;
      rpt.last      = 1'b1;
      for (int j = 0; j < OUT_SLOTS; j++) begin
         if (overflow) begin
            rpt.slots[j] = HID_OVF;
         end else if (j < KEY_SLOTS) begin
            rpt.slots[j] = held_usages[j];
         end else begin
            rpt.slots[j] = USAGE_NONE;
         end
      end
      return rpt;
   endfunction

   task automatic clear_held_report();
      held_mods = 8'h00;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         held_usages[i] = USAGE_NONE;
      end
   endtask

   // update the held report for one accepted transfer and queue its reports
   task automatic predict_reports(input mode_type mode, input logic [7:0] usage,
                                  input logic [7:0] mbits, input logic [7:0] ch);
      report_type  rpt;
      logic [15:0] code;
      int          slot;
      bit          found;
      case (mode)
         MODE_ASCII: begin
            // press then release, stored report left alone
            code = ch[7] ? 16'h0000 : US_KEYMAP[ch[6:0]];
            rpt.modifiers = code[15:8];
            rpt.slots     = '0;
            rpt.slots[0]  = code[7:0];
            rpt.last      = 1'b0;
            pending_reports.push_back(rpt);
            rpt = '0;
            rpt.last = 1'b1;
            pending_reports.push_back(rpt);
         end
         MODE_RESET: begin
            clear_held_report();
            pending_reports.push_back(held_report(1'b0));
         end
         MODE_PRESS: begin
            // modifiers first, then the key; usage 0 means no key
            held_mods = held_mods | mbits;
            slot = 0;
            if (usage != USAGE_NONE) begin
               for (slot = 0; slot < KEY_SLOTS; slot++) begin
                  if (held_usages[slot] == USAGE_NONE) begin
                     held_usages[slot] = usage;
                     break;
                  end
                  if (held_usages[slot] == usage) begin
                     break;
                  end
               end
            end
            pending_reports.push_back(held_report(slot == KEY_SLOTS));
         end
         default: begin
            // release: clear modifiers, remove the key and close the gap
            held_mods = held_mods & ~mbits;
            if (usage != USAGE_NONE) begin
               found = 1'b0;
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (found) begin
                     held_usages[i-1] = held_usages[i];
                  end else if (held_usages[i] == usage) begin
                     found = 1'b1;
                  end
               end
               if (found) begin
                  held_usages[KEY_SLOTS-1] = USAGE_NONE;
               end
            end
            pending_reports.push_back(held_report(1'b0));
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------------

   // offer one item and wait for its transfer; gaps come before bursts
   task automatic send_key(input mode_type mode, input logic [7:0] usage,
                           input logic [7:0] mbits, input logic [7:0] ch);
      int gap;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_usage         <= usage;
      req_modifier_bits <= mbits;
      req_ascii_char    <= ch;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      predict_reports(mode, usage, mbits, ch);
   endtask

   // stop offering, let every owed report come out, then let the bench idle
   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // output side
   // ------------------------------------------------------------------------

   // receiver stall pattern: a long hold-off when asked, else with receiver_gaps runs
   // of random length alternating between stalled and open, and no stall otherwise
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_gaps) begin
         if (stall_run == 0) begin
            stall_phase = ~stall_phase;
            stall_run   = stall_phase ? $urandom_range(1, 6) : $urandom_range(1, 10);
         end
         stall_run--;
         rsp_stall <= stall_phase;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("%0t transfer %0d: %s got %0h expected %0h", $time, rsp_count, what, got,
               want);
   endtask

   // every report transfer is compared with the oldest owed report
   always @(posedge clock) begin
      report_type want;
      logic [7:0] got_slots [OUT_SLOTS];
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         rsp_count++;
         got_slots = '{rsp_key_slot_one, rsp_key_slot_two, rsp_key_slot_three,
                       rsp_key_slot_four, rsp_key_slot_five, rsp_key_slot_six};
         if (pending_reports.size() == 0) begin
            report_mismatch("report with none owed", rsp_modifiers, 8'h00);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_modifiers !== want.modifiers) begin
               report_mismatch("modifiers", rsp_modifiers, want.modifiers);
            end
            for (int j = 0; j < OUT_SLOTS; j++) begin
               if (got_slots[j] !== want.slots[j]) begin
                  report_mismatch($sformatf("key slot %0d", j + 1), got_slots[j],
                                  want.slots[j]);
               end
            end
            if (rsp_last_of_run !== want.last) begin
               report_mismatch("last of run", {7'd0, rsp_last_of_run}, {7'd0, want.last});
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // extremes, slot filling, overflow, shifting release and ascii corners
   task automatic test_directed();
      send_key(MODE_PRESS,   8'h00, 8'h00, 8'h00);   // empty press
      send_key(MODE_PRESS,   8'hff, 8'hff, 8'hff);   // modifiers and key together
      send_key(MODE_RELEASE, 8'hff, 8'hff, 8'h00);
      send_key(MODE_PRESS,   8'h04, 8'h02, 8'h00);
      for (int u = 5; u <= 9; u++) begin
         send_key(MODE_PRESS, u[7:0], 8'h00, 8'h00);  // fill all six slots
      end
      send_key(MODE_PRESS,   8'h06, 8'h00, 8'h00);   // already held while full
      send_key(MODE_PRESS,   8'h0a, 8'h10, 8'h00);   // slots full, overflow
      send_key(MODE_RELEASE, 8'h33, 8'h00, 8'h00);   // absent key
      send_key(MODE_RELEASE, 8'h06, 8'h00, 8'h00);   // middle key, later ones move down
      send_key(MODE_PRESS,   8'h0a, 8'h00, 8'h00);   // now fits in the last slot
      send_key(MODE_RELEASE, 8'h04, 8'h02, 8'h00);   // first key and shift
      send_key(MODE_RELEASE, 8'h00, 8'h10, 8'h00);   // modifier only
      send_key(MODE_RESET,   8'h00, 8'h00, 8'h00);
      send_key(MODE_ASCII,   8'h00, 8'h00, 8'h00);
      for (int c = 28; c <= 31; c++) begin
         send_key(MODE_ASCII, 8'h00, 8'h00, c[7:0]);  // ctrl with punctuation
      end
      send_key(MODE_ASCII,   8'h00, 8'h00, 8'h7f);
      send_key(MODE_ASCII,   8'h00, 8'h00, 8'h80);   // above 127 maps to nothing
      send_key(MODE_ASCII,   8'hff, 8'hff, 8'hff);
      send_key(MODE_ASCII,   8'h00, 8'h00, "A");
      drain_reports();
   endtask

   // one random item: mostly presses and releases of a small key pool so the
   // slots fill, overflow and shift; some ascii, resets and raw noise
   task automatic random_typing_item();
      int         pick;
      logic [7:0] usage;
      logic [7:0] mbits;
      pick  = $urandom_range(0, 99);
      usage = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 3))
         0:       mbits = 8'h00;
         1:       mbits = 8'h01 << $urandom_range(0, 7);
         2:       mbits = 8'h00;
         default: mbits = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 9) == 0) begin
         usage = USAGE_NONE;
      end
      if (pick < 38) begin
         send_key(MODE_PRESS, usage, mbits, 8'($urandom_range(0, 255)));
      end else if (pick < 68) begin
         send_key(MODE_RELEASE, usage, mbits, 8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
         send_key(MODE_RESET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         send_key(MODE_ASCII, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else begin
         send_key(mode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   // long random run; traffic style and key pool change every so often,
   // including stretches with no gaps at all
   task automatic test_random_typing();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            sender_gaps   = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            if (n == 0) begin
               sender_gaps   = 1'b0;
               receiver_gaps = 1'b0;
            end
            for (int i = 0; i < POOL_SIZE; i++) begin
               key_pool[i] = 8'($urandom_range(1, 255));
            end
         end
         random_typing_item();
      end
      drain_reports();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering,
   // so the block fills up and stalls its input
   task automatic test_receiver_hold_off();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      hold_request  = HOLD_OFF_CYCLES;
      for (int n = 0; n < HOLD_OFF_ITEMS; n++) begin
         random_typing_item();
      end
      drain_reports();
   endtask

   initial begin
      clear_held_report();
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = 8'h04 + i[7:0];
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_receiver_hold_off();
      test_random_typing();
      test_receiver_hold_off();

      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/hidkb_pkg.sv
rtl/hidkb_key_table.sv
rtl/hidkb_rsp_stage.sv
rtl/hid_keyboard_report_builder.sv
sim/tb_top.sv
